// ----- design/afp_pkg.sv -----
// Shared constants and types for the ASCII position frame parser.
package afp_pkg;

    // Item function codes
    localparam logic FUNC_PARSE = 1'b0;
    localparam logic FUNC_TIME  = 1'b1;

    // ASCII codes recognized by the parser
    localparam logic [7:0] ASCII_X     = 8'h58;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_LF    = 8'h0A;
    localparam logic [7:0] ASCII_CR    = 8'h0D;

    // Accumulator: holds at most 9999
    localparam int unsigned ACC_W = 14;
    localparam logic [ACC_W-1:0] ACC_LIMIT = 14'd1000;
    localparam logic [ACC_W-1:0] ACC_MAX   = 14'd9999;
    localparam logic [ACC_W-1:0] POS_LIMIT = 14'd125;

    // Register file
    localparam int unsigned PADDR_W = 3;
    localparam logic REG_TIMEOUT = 1'b0;   // register index, paddr[2]
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    // Frame engine status toward the top level
    typedef struct packed {
        logic              accepted;   // this item closed a good frame
        logic signed [7:0] position;   // stored position after this item
        logic [31:0]       last_time;  // stored frame time before this item
    } frame_status_t;

endpackage

// ----- design/afp_frame.sv -----
// Frame state machine: parses one byte per step and holds the stored position.
module afp_frame import afp_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  logic [7:0]    rx_byte,
    input  logic [31:0]   now_ms,
    output frame_status_t status
);

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             neg_reg, neg_next;
    logic             in_frame_reg, in_frame_next;
    logic             has_digit_reg, has_digit_next;
    logic signed [7:0] pos_reg, pos_next;
    logic [31:0]      time_reg, time_next;
    logic             accepted;

    logic is_x, is_minus, is_digit, is_eol;

    assign is_x     = (rx_byte == ASCII_X);
    assign is_minus = (rx_byte == ASCII_MINUS);
    assign is_digit = (rx_byte >= ASCII_ZERO) && (rx_byte <= ASCII_NINE);
    assign is_eol   = (rx_byte == ASCII_LF) || (rx_byte == ASCII_CR);

    always_comb begin
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        in_frame_next  = in_frame_reg;
        has_digit_next = has_digit_reg;
        pos_next       = pos_reg;
        time_next      = time_reg;
        accepted       = 1'b0;
        if (step) begin
            priority if (is_x) begin
                acc_next       = '0;
                neg_next       = 1'b0;
                in_frame_next  = 1'b1;
                has_digit_next = 1'b0;
            end else if (in_frame_reg && is_minus) begin
                neg_next = 1'b1;
            end else if (in_frame_reg && is_digit) begin
                if (acc_reg < ACC_LIMIT) begin
                    // acc*10 + digit; the low nibble of '0'..'9' is the digit
                    acc_next = (acc_reg << 3) + (acc_reg << 1)
                             + {{(ACC_W-4){1'b0}}, rx_byte[3:0]};
                    has_digit_next = 1'b1;
                end
            end else if (in_frame_reg && is_eol) begin
                // -125..125 holds for either sign exactly when acc <= 125
                if (has_digit_reg && (acc_reg <= POS_LIMIT)) begin
                    pos_next  = neg_reg ? -$signed(acc_reg[7:0]) : $signed(acc_reg[7:0]);
                    time_next = now_ms;
                    accepted  = 1'b1;
                end
                in_frame_next = 1'b0;
            end else begin
                // byte ignored
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            in_frame_reg  <= 1'b0;
            has_digit_reg <= 1'b0;
            pos_reg       <= '0;
            time_reg      <= '0;
        end else begin
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            in_frame_reg  <= in_frame_next;
            has_digit_reg <= has_digit_next;
            pos_reg       <= pos_next;
            time_reg      <= time_next;
        end
    end

    assign status.accepted  = accepted;
    assign status.position  = pos_next;
    assign status.last_time = time_reg;

    a_acc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg <= ACC_MAX)
        else $error("accumulator above 9999");

    a_no_digit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !has_digit_reg |-> (acc_reg == '0))
        else $error("accumulator nonzero without a digit");

    a_accept_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accepted |=> (time_reg == $past(now_ms)))
        else $error("frame time not captured on accept");

endmodule

// ----- design/ascii_position_frame_parser.sv -----
// Top level of the ASCII position frame parser: handshake, register port, result stage.
//
// Parses frames such as "X:+123" ended by LF or CR, one byte per item, and
// returns one result per item: the stored position, a fresh flag and whether
// this byte closed an accepted frame. A frame is stored (with its now_ms)
// only if it held a digit and its value lies in -125..125. An item with
// func = 1 only checks the time. Throughput is one item per clock while
// m_ready does not hold back a waiting result: each item lands in the input
// register and then moves into the result register. Parse state advances at
// the edge where an item moves from the input register into the result
// register, so the next item already sees it. The result register frees the
// input side: a new item is taken while a finished result waits, as long as
// the input register is empty or moving. fresh means (now_ms - last frame
// time) mod 2^32 is at most timeout_ms (register 0, byte address 0, reset
// 100), judged after the item's own byte. timeout_ms is to be written over
// APB only while the block is idle; the block itself does not enforce this.
// pready is tied high.
module ascii_position_frame_parser import afp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // input items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic [7:0]         s_rx_byte,
    input  logic [31:0]        s_now_ms,
    // result items
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [7:0]  m_position_mm,
    output logic               m_fresh,
    output logic               m_frame_accepted,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // ---------------- register port ----------------
    logic [15:0] timeout_reg;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_TIMEOUT);
    assign prdata  = reg_sel ? {16'b0, timeout_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            timeout_reg <= pwdata[15:0];
        end
    end

    // ---------------- input register ----------------
    logic        in_valid_reg;
    logic        in_func_reg;
    logic [7:0]  in_byte_reg;
    logic [31:0] in_now_reg;
    logic        out_free;
    logic        advance;

    assign out_free = !m_valid || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg <= s_func;
            in_byte_reg <= s_rx_byte;
            in_now_reg  <= s_now_ms;
        end
    end

    // ---------------- frame engine ----------------
    frame_status_t frame_status;
    logic          parse_step;
    logic [31:0]   age;
    logic          fresh;

    assign parse_step = advance && (in_func_reg == FUNC_PARSE);

    afp_frame u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (parse_step),
        .rx_byte (in_byte_reg),
        .now_ms  (in_now_reg),
        .status  (frame_status)
    );

    // An accepted frame stores now_ms, so its age is zero and always fresh.
    assign age   = in_now_reg - frame_status.last_time;
    assign fresh = frame_status.accepted || (age <= {16'b0, timeout_reg});

    // ---------------- result register ----------------
    logic              m_valid_reg;
    logic signed [7:0] pos_out_reg;
    logic              fresh_reg;
    logic              accepted_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pos_out_reg  <= frame_status.position;
            fresh_reg    <= fresh;
            accepted_reg <= frame_status.accepted;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_position_mm    = pos_out_reg;
    assign m_fresh          = fresh_reg;
    assign m_frame_accepted = accepted_reg;

    // ---------------- checks ----------------
    a_accept_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_accepted) |-> m_fresh)
        else $error("accepted frame reported stale");

    a_accept_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_accepted) |->
            (($signed(m_position_mm) >= -8'sd125) && ($signed(m_position_mm) <= 8'sd125)))
        else $error("accepted position out of range");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (!in_valid_reg || !m_valid_reg) |-> s_ready)
        else $error("input stalled with a free stage");

endmodule
